### sv/clt_pkg.sv
// Shared types, codes and tables for the configuration language tokenizer.
`default_nettype none
package clt_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int WORD_BUFFER_CHARS_DEF = 8;
  localparam int MAX_RECS = 5;
  localparam int OUT_POS_W = 16;

  typedef enum logic [12:0] {
    M_IDLE      = 13'b0000000000001,
    M_WORD      = 13'b0000000000010,
    M_INT       = 13'b0000000000100,
    M_INTDOT    = 13'b0000000001000,
    M_FRAC      = 13'b0000000010000,
    M_STR       = 13'b0000000100000,
    M_ESC       = 13'b0000001000000,
    M_SLASH     = 13'b0000010000000,
    M_LINECMT   = 13'b0000100000000,
    M_BLOCK     = 13'b0001000000000,
    M_BLOCKSTAR = 13'b0010000000000,
    M_OP2       = 13'b0100000000000,
    M_ERROR     = 13'b1000000000000
  } mode_t;

  localparam logic [1:0] K_TEXT = 2'd0;
  localparam logic [1:0] K_END  = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;

  localparam logic [5:0] T_IDENT  = 6'd0;
  localparam logic [5:0] T_NUMBER = 6'd1;
  localparam logic [5:0] T_STRING = 6'd2;
  localparam logic [5:0] T_KW0    = 6'd3;
  localparam logic [5:0] T_DOT    = 6'd18;
  localparam logic [5:0] T_EOF    = 6'd33;

  localparam logic [1:0] E_STRING = 2'd0;
  localparam logic [1:0] E_AMP    = 2'd1;
  localparam logic [1:0] E_BAR    = 2'd2;
  localparam logic [1:0] E_CHAR   = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [5:0]           ttype;
    logic [7:0]           tbyte;
    logic [OUT_POS_W-1:0] line;
    logic [OUT_POS_W-1:0] col;
    logic [1:0]           err;
  } rec_t;

  typedef logic [7:0] kw_chars_t [7];
  localparam int NUM_KW = 7;
  localparam kw_chars_t KW_TEXT [NUM_KW] = '{
    '{"i", "n", "c", "l", "u", "d", "e"},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00},
    '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd7, 3'd2, 3'd4, 3'd6, 3'd4, 3'd5, 3'd4};

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic [5:0] single_type(input logic [7:0] b);
    case (b)
      "(": return 6'd10;
      ")": return 6'd11;
      "{": return 6'd12;
      "}": return 6'd13;
      "[": return 6'd14;
      "]": return 6'd15;
      ",": return 6'd16;
      ";": return 6'd17;
      ".": return 6'd18;
      "+": return 6'd19;
      "-": return 6'd20;
      default: return T_IDENT;
    endcase
  endfunction

endpackage
`default_nettype wire

### sv/config_language_tokenizer_top.sv
// Tokenizer top level: byte scanner, token state and result burst register.
//
//  channel | direction | fields
//  in      | input     | data_byte, is_end
//  out     | output    | record_kind, token_type, text_byte, token_line,
//          |           | token_column, error_code, run_last
//
// One input transaction is scanned in the cycle it is accepted; its 0 to 5
// records land in a burst register and leave one per cycle.
// A new byte is taken when no record waits or while the last record of the previous
// one is taken, so one byte per cycle when each byte yields at most one record and out is ready.
// Synchronous reset returns the scanner to idle at line 1, column 1.
// A stall on out holds the burst and blocks in until the burst drains.
`default_nettype none
module config_language_tokenizer_top
  import clt_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int WORD_BUFFER_CHARS = WORD_BUFFER_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        is_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       record_kind,
  output logic [5:0]       token_type,
  output logic [7:0]       text_byte,
  output logic [15:0]      token_line,
  output logic [15:0]      token_column,
  output logic [1:0]       error_code,
  output logic             run_last
);

  localparam int PB = POSITION_BITS;
  localparam int WB_IDX_W = $clog2(WORD_BUFFER_CHARS);
  localparam int WL_W = $clog2(WORD_BUFFER_CHARS + 2);
  localparam logic [PB-1:0] POS_ONE = PB'(1);

  mode_t          mode, mode_next;
  logic [7:0]     pend, pend_next;
  logic [PB-1:0]  cur_line, cur_line_next, cur_col, cur_col_next;
  logic [PB-1:0]  st_line, st_line_next, st_col, st_col_next;
  logic [PB-1:0]  dot_line, dot_line_next, dot_col, dot_col_next;
  logic [7:0]     wbuf [WORD_BUFFER_CHARS];
  logic [WL_W-1:0] wlen, wlen_next;
  logic           wb_we;
  logic [WB_IDX_W-1:0] wb_idx;

  rec_t           burst [MAX_RECS];
  logic [2:0]     bcnt, brd;
  rec_t           recs [MAX_RECS];
  logic [2:0]     n;
  logic [5:0]     kw_type;

  logic in_fire, out_fire;
  assign out_valid = brd < bcnt;
  assign out_fire = out_valid && out_ready;
  assign in_ready = !out_valid || (out_ready && (brd == bcnt - 3'd1));
  assign in_fire = in_valid && in_ready;

  assign record_kind  = burst[brd].kind;
  assign token_type   = burst[brd].ttype;
  assign text_byte    = burst[brd].tbyte;
  assign token_line   = burst[brd].line;
  assign token_column = burst[brd].col;
  assign error_code   = burst[brd].err;
  assign run_last     = brd == bcnt - 3'd1;

  function automatic rec_t mk(input logic [1:0] k, input logic [5:0] t, input logic [7:0] b,
                              input logic [PB-1:0] l, input logic [PB-1:0] c,
                              input logic [1:0] e);
    rec_t r;
    r.kind = k;
    r.ttype = t;
    r.tbyte = b;
    r.line = OUT_POS_W'(l);
    r.col = OUT_POS_W'(c);
    r.err = e;
    return r;
  endfunction

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  always_comb begin
    logic hit;
    kw_type = T_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      hit = wlen == WL_W'(KW_LEN[k]);
      for (int i = 0; i < 7; i++) begin
        if ((3'(i) < KW_LEN[k]) && (wbuf[i] != KW_TEXT[k][i])) hit = 1'b0;
      end
      if (hit) kw_type = T_KW0 + 6'(k);
    end
  end

  always_comb begin
    logic [7:0] b, eb, second;
    logic [5:0] one, two, st;
    logic do_idle;
    b = data_byte;
    mode_next = mode;
    pend_next = pend;
    cur_line_next = cur_line;
    cur_col_next = cur_col;
    st_line_next = st_line;
    st_col_next = st_col;
    dot_line_next = dot_line;
    dot_col_next = dot_col;
    wlen_next = wlen;
    wb_we = 1'b0;
    wb_idx = WB_IDX_W'(wlen);
    do_idle = 1'b0;
    n = 3'd0;
    for (int i = 0; i < MAX_RECS; i++) recs[i] = '0;
    second = "=";
    one = T_IDENT;
    two = 6'd32;
    case (pend)
      ":": begin one = 6'd21; two = 6'd22; second = ":"; end
      "=": begin one = 6'd23; two = 6'd24; end
      "!": begin one = 6'd25; two = 6'd26; end
      "<": begin one = 6'd27; two = 6'd28; end
      ">": begin one = 6'd29; two = 6'd30; end
      "&": begin two = 6'd31; second = "&"; end
      default: second = "|";
    endcase
    eb = b;
    case (b)
      "n": eb = 8'h0A;
      "t": eb = 8'h09;
      "r": eb = 8'h0D;
      "0": eb = 8'h00;
      default: eb = b;
    endcase

    if (is_end) begin
      unique case (mode)
        M_WORD: begin
          recs[n] = mk(K_END, kw_type, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
        end
        M_INT, M_FRAC: begin
          recs[n] = mk(K_END, T_NUMBER, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
        end
        M_INTDOT: begin
          recs[n] = mk(K_END, T_NUMBER, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
          recs[n] = mk(K_TEXT, T_DOT, ".", dot_line, dot_col, 2'd0); n = n + 3'd1;
          recs[n] = mk(K_END, T_DOT, 8'h00, dot_line, dot_col, 2'd0); n = n + 3'd1;
        end
        M_STR: begin
          recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_STRING); n = n + 3'd1;
        end
        M_ESC: begin
          recs[n] = mk(K_TEXT, T_STRING, "\\", st_line, st_col, 2'd0); n = n + 3'd1;
          recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_STRING); n = n + 3'd1;
        end
        M_SLASH: begin
          recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_CHAR); n = n + 3'd1;
        end
        M_OP2: begin
          if (pend == "&") begin
            recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_AMP); n = n + 3'd1;
          end else if (pend == "|") begin
            recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_BAR); n = n + 3'd1;
          end else begin
            recs[n] = mk(K_TEXT, one, pend, st_line, st_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_END, one, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
          end
        end
        default: ;
      endcase
      recs[n] = mk(K_END, T_EOF, 8'h00, cur_line, cur_col, 2'd0); n = n + 3'd1;
      mode_next = M_IDLE;
      pend_next = 8'h00;
      cur_line_next = POS_ONE;
      cur_col_next = POS_ONE;
      st_line_next = POS_ONE;
      st_col_next = POS_ONE;
      dot_line_next = POS_ONE;
      dot_col_next = POS_ONE;
      wlen_next = '0;
    end else begin
      unique case (mode)
        M_WORD: begin
          if (is_alpha(b) || is_digit(b) || b == "_") begin
            wb_we = wlen < WL_W'(WORD_BUFFER_CHARS);
            if (wlen <= WL_W'(WORD_BUFFER_CHARS)) wlen_next = wlen + 1'b1;
            recs[n] = mk(K_TEXT, T_IDENT, b, st_line, st_col, 2'd0); n = n + 3'd1;
          end else begin
            recs[n] = mk(K_END, kw_type, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(b)) begin
            recs[n] = mk(K_TEXT, T_NUMBER, b, st_line, st_col, 2'd0); n = n + 3'd1;
          end else if (b == ".") begin
            dot_line_next = cur_line;
            dot_col_next = cur_col;
            mode_next = M_INTDOT;
          end else begin
            recs[n] = mk(K_END, T_NUMBER, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_INTDOT: begin
          if (is_digit(b)) begin
            recs[n] = mk(K_TEXT, T_NUMBER, ".", st_line, st_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_TEXT, T_NUMBER, b, st_line, st_col, 2'd0); n = n + 3'd1;
            mode_next = M_FRAC;
          end else begin
            recs[n] = mk(K_END, T_NUMBER, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_TEXT, T_DOT, ".", dot_line, dot_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_END, T_DOT, 8'h00, dot_line, dot_col, 2'd0); n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(b)) begin
            recs[n] = mk(K_TEXT, T_NUMBER, b, st_line, st_col, 2'd0); n = n + 3'd1;
          end else begin
            recs[n] = mk(K_END, T_NUMBER, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (b == "\"") begin
            recs[n] = mk(K_END, T_STRING, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            mode_next = M_IDLE;
          end else if (b == "\\") begin
            mode_next = M_ESC;
          end else begin
            recs[n] = mk(K_TEXT, T_STRING, b, st_line, st_col, 2'd0); n = n + 3'd1;
          end
        end
        M_ESC: begin
          recs[n] = mk(K_TEXT, T_STRING, eb, st_line, st_col, 2'd0); n = n + 3'd1;
          mode_next = M_STR;
        end
        M_SLASH: begin
          if (b == "/") mode_next = M_LINECMT;
          else if (b == "*") mode_next = M_BLOCK;
          else begin
            recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_CHAR); n = n + 3'd1;
            mode_next = M_ERROR;
          end
        end
        M_LINECMT: begin
          if (b == 8'h0A) mode_next = M_IDLE;
        end
        M_BLOCK: begin
          if (b == "*") mode_next = M_BLOCKSTAR;
        end
        M_BLOCKSTAR: begin
          if (b == "/") mode_next = M_IDLE;
          else if (b != "*") mode_next = M_BLOCK;
        end
        M_OP2: begin
          if (b == second) begin
            recs[n] = mk(K_TEXT, two, pend, st_line, st_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_TEXT, two, second, st_line, st_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_END, two, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            mode_next = M_IDLE;
          end else if (pend == "&") begin
            recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_AMP); n = n + 3'd1;
            mode_next = M_ERROR;
          end else if (pend == "|") begin
            recs[n] = mk(K_ERR, T_IDENT, 8'h00, st_line, st_col, E_BAR); n = n + 3'd1;
            mode_next = M_ERROR;
          end else begin
            recs[n] = mk(K_TEXT, one, pend, st_line, st_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_END, one, 8'h00, st_line, st_col, 2'd0); n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_ERROR: ;
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next = M_IDLE;
        st = single_type(b);
        if (!(b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A)) begin
          st_line_next = cur_line;
          st_col_next = cur_col;
          if (b == "/") mode_next = M_SLASH;
          else if (b == "#") mode_next = M_LINECMT;
          else if (b == "\"") mode_next = M_STR;
          else if (is_digit(b)) begin
            mode_next = M_INT;
            recs[n] = mk(K_TEXT, T_NUMBER, b, cur_line, cur_col, 2'd0); n = n + 3'd1;
          end else if (is_alpha(b) || b == "_") begin
            mode_next = M_WORD;
            wb_we = 1'b1;
            wb_idx = '0;
            wlen_next = WL_W'(1);
            recs[n] = mk(K_TEXT, T_IDENT, b, cur_line, cur_col, 2'd0); n = n + 3'd1;
          end else if (st != T_IDENT) begin
            recs[n] = mk(K_TEXT, st, b, cur_line, cur_col, 2'd0); n = n + 3'd1;
            recs[n] = mk(K_END, st, 8'h00, cur_line, cur_col, 2'd0); n = n + 3'd1;
          end else if (b == ":" || b == "=" || b == "!" || b == "<" || b == ">" ||
                       b == "&" || b == "|") begin
            pend_next = b;
            mode_next = M_OP2;
          end else begin
            recs[n] = mk(K_ERR, T_IDENT, 8'h00, cur_line, cur_col, E_CHAR); n = n + 3'd1;
            mode_next = M_ERROR;
          end
        end
      end

      if (b == 8'h0A) begin
        cur_line_next = sat_inc(cur_line);
        cur_col_next = POS_ONE;
      end else begin
        cur_col_next = sat_inc(cur_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= 8'h00;
      cur_line <= POS_ONE;
      cur_col <= POS_ONE;
      st_line <= POS_ONE;
      st_col <= POS_ONE;
      dot_line <= POS_ONE;
      dot_col <= POS_ONE;
      wlen <= '0;
      bcnt <= 3'd0;
      brd <= 3'd0;
    end else begin
      if (in_fire) begin
        mode <= mode_next;
        pend <= pend_next;
        cur_line <= cur_line_next;
        cur_col <= cur_col_next;
        st_line <= st_line_next;
        st_col <= st_col_next;
        dot_line <= dot_line_next;
        dot_col <= dot_col_next;
        wlen <= wlen_next;
        bcnt <= n;
        brd <= 3'd0;
      end else if (out_fire) begin
        brd <= brd + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RECS; i++) burst[i] <= recs[i];
      if (wb_we) wbuf[wb_idx] <= data_byte;
    end
  end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the configuration language tokenizer.
`default_nettype none
module testbench
  import clt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] C_NL = 8'h0a;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_CR = 8'h0d;
  localparam logic [7:0] C_BSL = 8'h5c;
  localparam logic [7:0] C_QUOTE = 8'h22;

  localparam int SM_IDLE = 0, SM_WORD = 1, SM_INT = 2, SM_INTDOT = 3, SM_FRAC = 4,
    SM_STR = 5, SM_ESC = 6, SM_SLASH = 7, SM_LINECMT = 8, SM_BLOCK = 9,
    SM_BLOCKSTAR = 10, SM_OP2 = 11, SM_ERROR = 12;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] ttype;
    logic [7:0] tbyte;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0] err;
    logic last;
  } record_t;

  typedef struct {
    logic [7:0] b;
    logic e;
    int fixed;  // 1: first record typed in below
    record_t rec;
  } stim_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [7:0] data_byte = 0;
  logic is_end = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] record_kind;
  logic [5:0] token_type;
  logic [7:0] text_byte;
  logic [15:0] token_line, token_column;
  logic [1:0] error_code;
  logic run_last;

  config_language_tokenizer_top DUT (.*);

  initial forever #1 clk = ~clk;
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // scanner model state
  int lmode;
  logic [7:0] pend_op;
  logic [15:0] cur_line, cur_col, st_line, st_col, dot_line, dot_col;
  logic [7:0] wbuf [8];
  int wlen;

  record_t expected_records[$];
  record_t burst[$];
  int errors = 0, tokens_seen = 0, errs_seen = 0;
  int send_idle = 12, recv_idle = 55;

  function automatic void emit(logic [1:0] k, logic [5:0] t, logic [7:0] by,
                               logic [15:0] l, logic [15:0] c, logic [1:0] e);
    record_t r;
    r.kind = k; r.ttype = t; r.tbyte = by; r.line = l; r.col = c; r.err = e; r.last = 0;
    if (burst.size() < MAX_RECS) burst = {burst, r};
  endfunction

  function automatic void lex_fail(logic [1:0] code, logic [15:0] l, logic [15:0] c);
    emit(K_ERR, 0, 0, l, c, code);
    lmode = SM_ERROR;
  endfunction

  function automatic logic digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic int punct(logic [7:0] b);
    case (b)
      "(": return 10; ")": return 11; "{": return 12; "}": return 13;
      "[": return 14; "]": return 15; ",": return 16; ";": return 17;
      ".": return 18; "+": return 19; "-": return 20;
      default: return -1;
    endcase
  endfunction

  function automatic logic [5:0] classify_word();
    string kws[7] = '{"include", "if", "else", "return", "true", "false", "null"};
    int i;
    for (int k = 0; k < 7; k++) begin
      if (wlen != kws[k].len()) continue;
      for (i = 0; i < wlen; i++)
        if (wbuf[i] != kws[k][i]) break;
      if (i == wlen) return T_KW0 + 6'(k);
    end
    return T_IDENT;
  endfunction

  function automatic void word_push(logic [7:0] b);
    if (wlen < 8) wbuf[wlen] = b;
    if (wlen <= 8) wlen++;
  endfunction

  function automatic void op_pair(logic [7:0] p, output logic [5:0] one,
                                  output logic [5:0] two, output logic [7:0] sec);
    sec = "=";
    case (p)
      ":": begin one = 21; two = 22; sec = ":"; end
      "=": begin one = 23; two = 24; end
      "!": begin one = 25; two = 26; end
      "<": begin one = 27; two = 28; end
      ">": begin one = 29; two = 30; end
      "&": begin one = 0; two = 31; sec = "&"; end
      default: begin one = 0; two = 32; sec = "|"; end
    endcase
  endfunction

  function automatic void start_token(logic [7:0] b, logic [15:0] l, logic [15:0] c);
    int t;
    lmode = SM_IDLE;
    if (b == " " || b == C_TAB || b == C_CR || b == C_NL) return;
    st_line = l; st_col = c;
    t = punct(b);
    if (b == "/") lmode = SM_SLASH;
    else if (b == "#") lmode = SM_LINECMT;
    else if (b == C_QUOTE) lmode = SM_STR;
    else if (digit(b)) begin
      lmode = SM_INT; emit(K_TEXT, T_NUMBER, b, st_line, st_col, 0);
    end else if (alpha(b) || b == "_") begin
      lmode = SM_WORD; wlen = 0; word_push(b);
      emit(K_TEXT, T_IDENT, b, st_line, st_col, 0);
    end else if (t >= 0) begin
      emit(K_TEXT, 6'(t), b, st_line, st_col, 0);
      emit(K_END, 6'(t), 0, st_line, st_col, 0);
    end else if (b == ":" || b == "=" || b == "!" || b == "<" || b == ">" ||
                 b == "&" || b == "|") begin
      pend_op = b; lmode = SM_OP2;
    end else lex_fail(E_CHAR, l, c);
  endfunction

  function automatic void dot_split();
    emit(K_END, T_NUMBER, 0, st_line, st_col, 0);
    emit(K_TEXT, T_DOT, ".", dot_line, dot_col, 0);
    emit(K_END, T_DOT, 0, dot_line, dot_col, 0);
  endfunction

  function automatic void lexer_clear();
    lmode = SM_IDLE; pend_op = 0;
    cur_line = 1; cur_col = 1; st_line = 1; st_col = 1; dot_line = 1; dot_col = 1;
    wlen = 0;
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic e);
    logic [5:0] one, two;
    logic [7:0] sec, x;
    logic [15:0] l, c;
    burst.delete();
    l = cur_line; c = cur_col;
    if (e) begin
      case (lmode)
        SM_WORD: emit(K_END, classify_word(), 0, st_line, st_col, 0);
        SM_INT, SM_FRAC: emit(K_END, T_NUMBER, 0, st_line, st_col, 0);
        SM_INTDOT: dot_split();
        SM_STR: lex_fail(E_STRING, st_line, st_col);
        SM_ESC: begin
          emit(K_TEXT, T_STRING, C_BSL, st_line, st_col, 0);
          lex_fail(E_STRING, st_line, st_col);
        end
        SM_SLASH: lex_fail(E_CHAR, st_line, st_col);
        SM_OP2: begin
          op_pair(pend_op, one, two, sec);
          if (pend_op == "&") lex_fail(E_AMP, st_line, st_col);
          else if (pend_op == "|") lex_fail(E_BAR, st_line, st_col);
          else begin
            emit(K_TEXT, one, pend_op, st_line, st_col, 0);
            emit(K_END, one, 0, st_line, st_col, 0);
          end
        end
        default: ;
      endcase
      emit(K_END, T_EOF, 0, cur_line, cur_col, 0);
      lexer_clear();
    end else begin
      case (lmode)
        SM_WORD:
          if (alpha(b) || digit(b) || b == "_") begin
            word_push(b); emit(K_TEXT, T_IDENT, b, st_line, st_col, 0);
          end else begin
            emit(K_END, classify_word(), 0, st_line, st_col, 0); start_token(b, l, c);
          end
        SM_INT:
          if (digit(b)) emit(K_TEXT, T_NUMBER, b, st_line, st_col, 0);
          else if (b == ".") begin dot_line = l; dot_col = c; lmode = SM_INTDOT; end
          else begin emit(K_END, T_NUMBER, 0, st_line, st_col, 0); start_token(b, l, c); end
        SM_INTDOT:
          if (digit(b)) begin
            emit(K_TEXT, T_NUMBER, ".", st_line, st_col, 0);
            emit(K_TEXT, T_NUMBER, b, st_line, st_col, 0);
            lmode = SM_FRAC;
          end else begin dot_split(); start_token(b, l, c); end
        SM_FRAC:
          if (digit(b)) emit(K_TEXT, T_NUMBER, b, st_line, st_col, 0);
          else begin emit(K_END, T_NUMBER, 0, st_line, st_col, 0); start_token(b, l, c); end
        SM_STR:
          if (b == C_QUOTE) begin emit(K_END, T_STRING, 0, st_line, st_col, 0); lmode = SM_IDLE; end
          else if (b == C_BSL) lmode = SM_ESC;
          else emit(K_TEXT, T_STRING, b, st_line, st_col, 0);
        SM_ESC: begin
          x = b;
          if (b == "n") x = C_NL;
          else if (b == "t") x = C_TAB;
          else if (b == "r") x = C_CR;
          else if (b == "0") x = 0;
          emit(K_TEXT, T_STRING, x, st_line, st_col, 0);
          lmode = SM_STR;
        end
        SM_SLASH:
          if (b == "/") lmode = SM_LINECMT;
          else if (b == "*") lmode = SM_BLOCK;
          else lex_fail(E_CHAR, st_line, st_col);
        SM_LINECMT: if (b == C_NL) lmode = SM_IDLE;
        SM_BLOCK: if (b == "*") lmode = SM_BLOCKSTAR;
        SM_BLOCKSTAR:
          if (b == "/") lmode = SM_IDLE;
          else if (b != "*") lmode = SM_BLOCK;
        SM_OP2: begin
          op_pair(pend_op, one, two, sec);
          if (b == sec) begin
            emit(K_TEXT, two, pend_op, st_line, st_col, 0);
            emit(K_TEXT, two, sec, st_line, st_col, 0);
            emit(K_END, two, 0, st_line, st_col, 0);
            lmode = SM_IDLE;
          end else if (pend_op == "&") lex_fail(E_AMP, st_line, st_col);
          else if (pend_op == "|") lex_fail(E_BAR, st_line, st_col);
          else begin
            emit(K_TEXT, one, pend_op, st_line, st_col, 0);
            emit(K_END, one, 0, st_line, st_col, 0);
            start_token(b, l, c);
          end
        end
        SM_ERROR: ;
        default: start_token(b, l, c);
      endcase
      if (b == C_NL) begin
        if (cur_line != 16'hffff) cur_line++;
        cur_col = 1;
      end else if (cur_col != 16'hffff) cur_col++;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1;
  endfunction

  // drive one transaction; the first expected record may be typed in
  task automatic send_byte(logic [7:0] b, logic e, int fixed = 0, record_t rec = '{default: 0});
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    predict_tokens(b, e);
    if (fixed && burst.size() == 0) begin
      $error("table row b=%h: typed record but none predicted", b);
      errors++;
    end else if (fixed) begin
      rec.last = burst[0].last;
      if (rec != burst[0]) begin
        $error("table row b=%h: typed record disagrees with prediction", b);
        errors++;
      end
      burst[0] = rec;
    end
    foreach (burst[i]) expected_records = {expected_records, burst[i]};
    in_valid <= 1; data_byte <= b; is_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    record_t x;
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("record with nothing expected: kind=%0d", record_kind);
        errors++;
      end else begin
        x = expected_records.pop_front();
        if (record_kind == K_END) tokens_seen++;
        if (record_kind == K_ERR) errs_seen++;
        if (record_kind !== x.kind) begin
          $error("record_kind exp %0d got %0d", x.kind, record_kind); errors++;
        end
        if (token_type !== x.ttype) begin
          $error("token_type exp %0d got %0d", x.ttype, token_type); errors++;
        end
        if (text_byte !== x.tbyte) begin
          $error("text_byte exp %h got %h", x.tbyte, text_byte); errors++;
        end
        if (token_line !== x.line) begin
          $error("token_line exp %0d got %0d", x.line, token_line); errors++;
        end
        if (token_column !== x.col) begin
          $error("token_column exp %0d got %0d", x.col, token_column); errors++;
        end
        if (error_code !== x.err) begin
          $error("error_code exp %0d got %0d", x.err, error_code); errors++;
        end
        if (run_last !== x.last) begin
          $error("run_last exp %0d got %0d", x.last, run_last); errors++;
        end
      end
    end
  end

  localparam string FRAGS[22] = '{"include", "if", "else", "return", "true", "false", "null",
    "abc_9", "x", "longidentifier", "12", "3.14", "7.", "\"hi\\n\\t\\q\"", "// c\n",
    "# c\n", "/* a * b **/", "::", "==", "!=", "&&", "||"};
  localparam string OPS = "(){}[],;.+-:=!<>&|/ \t\r\n\"_*#";

  initial begin
    stim_t table_rows[$];
    int n;
    logic [7:0] b;
    lexer_clear();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    table_rows = '{
      '{8'h00, 1, 1, '{K_END, T_EOF, 0, 16'd1, 16'd1, 0, 1}},
      '{"(", 0, 1, '{K_TEXT, 6'd10, "(", 16'd1, 16'd1, 0, 0}},
      '{"1", 0, 1, '{K_TEXT, T_NUMBER, "1", 16'd1, 16'd2, 0, 1}},
      '{".", 0, 0, '{default: 0}},
      '{"x", 0, 1, '{K_END, T_NUMBER, 0, 16'd1, 16'd2, 0, 0}},
      '{"&", 0, 0, '{default: 0}},
      '{"b", 0, 1, '{K_ERR, 0, 0, 16'd1, 16'd5, E_AMP, 1}},
      '{"&", 0, 0, '{default: 0}},
      '{" ", 0, 0, '{default: 0}},
      '{8'hff, 0, 0, '{default: 0}},
      '{8'h00, 1, 0, '{default: 0}},
      '{"|", 0, 0, '{default: 0}},
      '{"x", 0, 1, '{K_ERR, 0, 0, 16'd1, 16'd1, E_BAR, 1}},
      '{8'h00, 1, 0, '{default: 0}},
      '{"/", 0, 0, '{default: 0}},
      '{"a", 0, 1, '{K_ERR, 0, 0, 16'd1, 16'd1, E_CHAR, 1}},
      '{8'h00, 1, 0, '{default: 0}},
      '{C_QUOTE, 0, 0, '{default: 0}},
      '{C_BSL, 0, 0, '{default: 0}},
      '{8'h00, 1, 1, '{K_TEXT, T_STRING, C_BSL, 16'd1, 16'd1, 0, 0}},
      '{"@", 0, 1, '{K_ERR, 0, 0, 16'd1, 16'd1, E_CHAR, 1}},
      '{8'h00, 1, 0, '{default: 0}},
      '{"<", 0, 0, '{default: 0}},
      '{8'h00, 1, 1, '{K_TEXT, 6'd27, "<", 16'd1, 16'd1, 0, 0}}
    };
    foreach (table_rows[i])
      send_byte(table_rows[i].b, table_rows[i].e, table_rows[i].fixed, table_rows[i].rec);

    // random sources, three idling phases
    n = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 55 : 0;
      recv_idle = (ph == 0) ? 55 : (ph == 1) ? 12 : 0;
      repeat (2) begin
        repeat ($urandom_range(5, 9)) begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
              send_text(FRAGS[$urandom_range(21)]); n++;
            end
            5, 6: begin send_byte(OPS[$urandom_range(OPS.len() - 1)], 0); n++; end
            7: begin send_byte(8'($urandom_range(255)), 0); n++; end
            8: begin send_byte(" ", 0); n++; end
            default: begin send_byte(C_NL, 0); n++; end
          endcase
        end
        b = 8'($urandom_range(255));
        send_byte(b, 1);
      end
    end
    send_text("a.1 ");
    send_byte(8'h00, 1);
    in_valid <= 0;

    while (expected_records.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d tokens, %0d errors over directed rows and %0d random picks",
             tokens_seen, errs_seen, n);
    $display("random sources ran under three sender and receiver idling mixes");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
